[design/s3ls_pkg.sv]
// Package for the 3x3 Cramer's rule solver: field widths, payload structs
// and the internal word types. Depends on nothing.
`default_nettype none
package s3ls_pkg;

	localparam int IN_W   = 16;
	localparam int OUT_W  = 32;
	localparam int FRAC_W = OUT_W / 2;
	localparam int GUARD_W = OUT_W - FRAC_W;
	localparam int PROD_W = 2 * IN_W;
	localparam int COF_W  = (2 * IN_W + 1 > 64) ? 64 : 2 * IN_W + 1;
	localparam int SUM_W  = (3 * IN_W + 2 > 64) ? 64 : 3 * IN_W + 2;
	localparam int REM_W  = SUM_W + OUT_W;
	// Length of the top-level valid chain, counting the done register.
	localparam int LAT    = OUT_W + 7;

	typedef logic signed [IN_W-1:0]   elem_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [COF_W-1:0]  cof_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [OUT_W-1:0]  sol_t;

	typedef struct packed {
		elem_t m00;
		elem_t m01;
		elem_t m02;
		elem_t m10;
		elem_t m11;
		elem_t m12;
		elem_t m20;
		elem_t m21;
		elem_t m22;
		elem_t rhs0;
		elem_t rhs1;
		elem_t rhs2;
	} s3ls_in_t;

	typedef struct packed {
		sol_t sol0;
		sol_t sol1;
		sol_t sol2;
		logic singular;
		logic overflow;
	} s3ls_out_t;

	typedef struct packed {
		cof_t c0;
		cof_t c1;
		cof_t c2;
	} cof_row_t;

	typedef struct packed {
		elem_t b0;
		elem_t b1;
		elem_t b2;
	} vec_t;

	typedef struct packed {
		sol_t sol;
		logic sat;
		logic sing;
	} lane_res_t;

endpackage
`default_nettype wire

[design/solve_3x3_linear_system_top.sv]
// Top level of the 3x3 Cramer's rule solver: front end, three solution lanes
// and the merging output stage. Depends on s3ls_pkg, s3ls_front, s3ls_lane.
//
//   channel   handshake       payload   direction
//   request   start / busy    req       in
//   result    done (strobe)   res       out
//
// A request is taken on every cycle with start high; busy is always low.
// Each result appears on res for one cycle with done. It passes through
// five stages of products and sums, then the per-lane divider pipeline,
// one quotient bit per stage, then the lane and output result registers.
// Reset clears only the valid chain; the receiver cannot stall the result.
`default_nettype none
module solve_3x3_linear_system_top
	import s3ls_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  s3ls_in_t  req,
	output logic      done,
	output s3ls_out_t res
);

	cof_row_t  cof_s2 [3];
	vec_t      rhs_s2;
	sum_t      det_s4;
	lane_res_t lane_res [3];
	logic [LAT-2:0] vld_q;
	logic done_q;
	s3ls_out_t res_q;

	assign busy = 1'b0;

	s3ls_front u_front (
		.clk    (clk),
		.req    (req),
		.cof_s2 (cof_s2),
		.rhs_s2 (rhs_s2),
		.det_s4 (det_s4)
	);

	for (genvar i = 0; i < 3; i++) begin : g_lane
		s3ls_lane u_lane (
			.clk     (clk),
			.cof_row (cof_s2[i]),
			.rhs     (rhs_s2),
			.det     (det_s4),
			.res_q   (lane_res[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[LAT-3:0], start};
			done_q <= vld_q[LAT-2];
		end
	end

	always_ff @(posedge clk) begin
		res_q.sol0     <= lane_res[0].sol;
		res_q.sol1     <= lane_res[1].sol;
		res_q.sol2     <= lane_res[2].sol;
		res_q.singular <= lane_res[0].sing;
		res_q.overflow <= lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;
	end

	assign done = done_q;
	assign res  = res_q;

	localparam sol_t SolMax = {1'b0, {(OUT_W-1){1'b1}}};
	localparam sol_t SolMin = {1'b1, {(OUT_W-1){1'b0}}};

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.singular |-> res.sol0 == '0 && res.sol1 == '0 &&
			res.sol2 == '0 && !res.overflow)
		else $error("singular result carries nonzero data");

	a_ovf_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.overflow |-> !res.singular)
		else $error("overflow raised on a singular result");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.overflow |-> res.sol0 == SolMax || res.sol0 == SolMin ||
			res.sol1 == SolMax || res.sol1 == SolMin ||
			res.sol2 == SolMax || res.sol2 == SolMin)
		else $error("overflow without a saturated component");

endmodule
`default_nettype wire

[design/s3ls_front.sv]
// Front end of the solver: the nine adjugate cofactors and the determinant.
// Depends on s3ls_pkg.
`default_nettype none
module s3ls_front
	import s3ls_pkg::*;
(
	input  wire logic     clk,
	input  s3ls_in_t      req,
	output cof_row_t      cof_s2 [3],
	output vec_t          rhs_s2,
	output sum_t          det_s4
);

	prod_t pos_s1 [9];
	prod_t neg_s1 [9];
	elem_t a0_s1 [3];
	elem_t a0_s2 [3];
	vec_t  rhs_s1;
	sum_t  det_p_s3 [3];

	always_ff @(posedge clk) begin
		pos_s1[0] <= req.m11 * req.m22;  neg_s1[0] <= req.m21 * req.m12;
		pos_s1[1] <= req.m21 * req.m02;  neg_s1[1] <= req.m01 * req.m22;
		pos_s1[2] <= req.m01 * req.m12;  neg_s1[2] <= req.m11 * req.m02;
		pos_s1[3] <= req.m20 * req.m12;  neg_s1[3] <= req.m10 * req.m22;
		pos_s1[4] <= req.m00 * req.m22;  neg_s1[4] <= req.m20 * req.m02;
		pos_s1[5] <= req.m10 * req.m02;  neg_s1[5] <= req.m00 * req.m12;
		pos_s1[6] <= req.m10 * req.m21;  neg_s1[6] <= req.m20 * req.m11;
		pos_s1[7] <= req.m20 * req.m01;  neg_s1[7] <= req.m00 * req.m21;
		pos_s1[8] <= req.m00 * req.m11;  neg_s1[8] <= req.m01 * req.m10;
		a0_s1[0] <= req.m00;
		a0_s1[1] <= req.m01;
		a0_s1[2] <= req.m02;
		rhs_s1 <= '{b0: req.rhs0, b1: req.rhs1, b2: req.rhs2};
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			cof_s2[i].c0 <= cof_t'(pos_s1[3*i])   - cof_t'(neg_s1[3*i]);
			cof_s2[i].c1 <= cof_t'(pos_s1[3*i+1]) - cof_t'(neg_s1[3*i+1]);
			cof_s2[i].c2 <= cof_t'(pos_s1[3*i+2]) - cof_t'(neg_s1[3*i+2]);
			a0_s2[i] <= a0_s1[i];
		end
		rhs_s2 <= rhs_s1;
	end

	// Expansion along row 0 uses the first column of the adjugate.
	always_ff @(posedge clk) begin
		det_p_s3[0] <= sum_t'(a0_s2[0]) * sum_t'(cof_s2[0].c0);
		det_p_s3[1] <= sum_t'(a0_s2[1]) * sum_t'(cof_s2[1].c0);
		det_p_s3[2] <= sum_t'(a0_s2[2]) * sum_t'(cof_s2[2].c0);
		det_s4 <= det_p_s3[0] + det_p_s3[1] + det_p_s3[2];
	end

endmodule
`default_nettype wire

[design/s3ls_lane.sv]
// One solution lane: cofactor row dot right-hand side, then a pipelined
// restoring divider by the determinant with saturation. Depends on s3ls_pkg.
`default_nettype none
module s3ls_lane
	import s3ls_pkg::*;
(
	input  wire logic clk,
	input  cof_row_t  cof_row,
	input  vec_t      rhs,
	input  sum_t      det,
	output lane_res_t res_q
);

	sum_t dp_s3 [3];
	sum_t dot_s4;
	logic [SUM_W-1:0] nm_s5;
	logic [SUM_W-1:0] dm_s5;
	logic neg_s5;
	logic sing_s5;

	logic [REM_W-1:0] rem_sd [OUT_W];
	logic [SUM_W-1:0] dm_sd [OUT_W];
	logic [OUT_W-1:0] q_sd [OUT_W];
	logic neg_sd [OUT_W];
	logic sing_sd [OUT_W];
	logic big_sd [OUT_W];

	always_ff @(posedge clk) begin
		dp_s3[0] <= sum_t'(cof_row.c0) * sum_t'(rhs.b0);
		dp_s3[1] <= sum_t'(cof_row.c1) * sum_t'(rhs.b1);
		dp_s3[2] <= sum_t'(cof_row.c2) * sum_t'(rhs.b2);
		dot_s4 <= dp_s3[0] + dp_s3[1] + dp_s3[2];
		nm_s5 <= dot_s4[SUM_W-1] ? SUM_W'(-dot_s4) : SUM_W'(dot_s4);
		dm_s5 <= det[SUM_W-1] ? SUM_W'(-det) : SUM_W'(det);
		neg_s5 <= dot_s4[SUM_W-1] ^ det[SUM_W-1];
		sing_s5 <= (det == '0);
	end

	// Stage j decides quotient bit OUT_W-1-j of (|dot| << FRAC_W) / |det|.
	for (genvar j = 0; j < OUT_W; j++) begin : g_div
		logic [REM_W-1:0] rem_in;
		logic [SUM_W-1:0] dm_in;
		logic [OUT_W-1:0] q_in;
		logic neg_in;
		logic sing_in;
		logic big_in;
		logic [REM_W-1:0] trial;
		logic ge;

		if (j == 0) begin : g_first
			assign rem_in  = {{GUARD_W{1'b0}}, nm_s5, {FRAC_W{1'b0}}};
			assign dm_in   = dm_s5;
			assign q_in    = '0;
			assign neg_in  = neg_s5;
			assign sing_in = sing_s5;
			// The quotient needs more than OUT_W bits when this holds.
			assign big_in  = {{GUARD_W{1'b0}}, nm_s5} >= {dm_s5, {GUARD_W{1'b0}}};
		end else begin : g_next
			assign rem_in  = rem_sd[j-1];
			assign dm_in   = dm_sd[j-1];
			assign q_in    = q_sd[j-1];
			assign neg_in  = neg_sd[j-1];
			assign sing_in = sing_sd[j-1];
			assign big_in  = big_sd[j-1];
		end

		assign trial = REM_W'(dm_in) << (OUT_W - 1 - j);
		assign ge    = (rem_in >= trial);

		always_ff @(posedge clk) begin
			rem_sd[j]  <= ge ? rem_in - trial : rem_in;
			dm_sd[j]   <= dm_in;
			q_sd[j]    <= {q_in[OUT_W-2:0], ge};
			neg_sd[j]  <= neg_in;
			sing_sd[j] <= sing_in;
			big_sd[j]  <= big_in;
		end
	end

	logic [OUT_W-1:0] quo;
	logic fin_neg;
	logic fin_sat;
	logic fin_sing;

	assign quo      = q_sd[OUT_W-1];
	assign fin_neg  = neg_sd[OUT_W-1];
	assign fin_sing = sing_sd[OUT_W-1];
	// The most negative value is exact; the same magnitude as a positive saturates.
	assign fin_sat  = !fin_sing && (big_sd[OUT_W-1] ||
		(quo[OUT_W-1] && ((|quo[OUT_W-2:0]) || !fin_neg)));

	always_ff @(posedge clk) begin
		res_q.sing <= fin_sing;
		res_q.sat  <= fin_sat;
		if (fin_sing) begin
			res_q.sol <= '0;
		end else if (fin_sat) begin
			res_q.sol <= fin_neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
		end else begin
			res_q.sol <= fin_neg ? -quo : quo;
		end
	end

endmodule
`default_nettype wire

[tb/solve_3x3_linear_system_top_tb.sv]
// Testbench for the 3x3 Cramer's rule solver: drives requests, predicts each
// solution exactly with 64-bit integer math, checks results in order.
// Depends on s3ls_pkg and solve_3x3_linear_system_top.
`timescale 1ns / 100ps
module solve_3x3_linear_system_top_tb;
	import s3ls_pkg::*;

	class solution_board;
		s3ls_out_t pending[$];
		int n_fail;
		int n_req;
		int n_res;
		int n_sing;
		int n_ovf;

		function new();
			n_fail = 0;
			n_req = 0;
			n_res = 0;
			n_sing = 0;
			n_ovf = 0;
		endfunction

		// Fixed-point quotient of num * 2^FRAC_W / den, truncated toward zero.
		function sol_t scaled_quot(longint num, longint den, ref bit sat);
			bit neg;
			longint unsigned nm, dm, q0, r, f, lim, q;
			neg = (num < 0) != (den < 0);
			nm = (num < 0) ? -num : num;
			dm = (den < 0) ? -den : den;
			q0 = nm / dm;
			r = nm % dm;
			f = 0;
			for (int i = 0; i < FRAC_W; i++) begin
				r = r << 1;
				f = f << 1;
				if (r >= dm) begin
					r = r - dm;
					f = f | 1;
				end
			end
			lim = 64'd1 << (OUT_W - 1 - FRAC_W);
			if (q0 > lim || (q0 == lim && (!neg || f != 0))) begin
				sat = 1;
				return neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
			end
			q = (q0 << FRAC_W) | f;
			if (neg)
				q = -q;
			return q[OUT_W-1:0];
		endfunction

		function void note_request(s3ls_in_t r);
			longint a[3][3];
			longint b[3];
			longint c[3][3];
			longint det, dot;
			s3ls_out_t e;
			bit sat;
			a[0][0] = r.m00; a[0][1] = r.m01; a[0][2] = r.m02;
			a[1][0] = r.m10; a[1][1] = r.m11; a[1][2] = r.m12;
			a[2][0] = r.m20; a[2][1] = r.m21; a[2][2] = r.m22;
			b[0] = r.rhs0; b[1] = r.rhs1; b[2] = r.rhs2;
			sat = 0;
			e = '0;
			n_req++;
			det = a[0][0] * a[1][1] * a[2][2] + a[0][1] * a[1][2] * a[2][0]
				+ a[1][0] * a[2][1] * a[0][2] - a[1][1] * a[2][0] * a[0][2]
				- a[2][2] * a[1][0] * a[0][1] - a[0][0] * a[2][1] * a[1][2];
			if (det == 0) begin
				e.singular = 1;
				pending.push_back(e);
				return;
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					// Adjugate entry: cofactor of element (j, i).
					c[i][j] = a[(j+1)%3][(i+1)%3] * a[(j+2)%3][(i+2)%3]
						- a[(j+1)%3][(i+2)%3] * a[(j+2)%3][(i+1)%3];
			dot = c[0][0] * b[0] + c[0][1] * b[1] + c[0][2] * b[2];
			e.sol0 = scaled_quot(dot, det, sat);
			dot = c[1][0] * b[0] + c[1][1] * b[1] + c[1][2] * b[2];
			e.sol1 = scaled_quot(dot, det, sat);
			dot = c[2][0] * b[0] + c[2][1] * b[1] + c[2][2] * b[2];
			e.sol2 = scaled_quot(dot, det, sat);
			e.overflow = sat;
			pending.push_back(e);
		endfunction

		function void check_result(s3ls_out_t got);
			s3ls_out_t e;
			n_res++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				n_fail++;
				return;
			end
			e = pending.pop_front();
			if (got.singular) n_sing++;
			if (got.overflow) n_ovf++;
			if (got.sol0 !== e.sol0) begin
				$display("%0t: sol0 expected %h actual %h", $time, e.sol0, got.sol0);
				n_fail++;
			end
			if (got.sol1 !== e.sol1) begin
				$display("%0t: sol1 expected %h actual %h", $time, e.sol1, got.sol1);
				n_fail++;
			end
			if (got.sol2 !== e.sol2) begin
				$display("%0t: sol2 expected %h actual %h", $time, e.sol2, got.sol2);
				n_fail++;
			end
			if (got.singular !== e.singular) begin
				$display("%0t: singular expected %b actual %b", $time, e.singular,
					got.singular);
				n_fail++;
			end
			if (got.overflow !== e.overflow) begin
				$display("%0t: overflow expected %b actual %b", $time, e.overflow,
					got.overflow);
				n_fail++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	s3ls_in_t req;
	logic done;
	s3ls_out_t res;
	bit calm;
	solution_board board;

	solve_3x3_linear_system_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.res(res)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(res);
	end

	function automatic elem_t rand_elem(int mode);
		case (mode)
			0: return elem_t'($urandom);
			1: return elem_t'($urandom_range(0, 1023)) - 512;
			2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
			default: return elem_t'($urandom_range(0, 8)) - 4;
		endcase
	endfunction

	// Presents one request and holds it until the block takes it.
	task automatic send_request(s3ls_in_t r);
		if (!calm && $urandom_range(0, 99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_request(r);
		@(negedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_matrix(elem_t v[12]);
		s3ls_in_t r;
		r = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
		send_request(r);
	endtask

	initial begin
		elem_t v[12];
		int mode;
		board = new();
		calm = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// All zero: singular.
		foreach (v[i]) v[i] = 0;
		send_matrix(v);
		// Scaled identity (256 on the diagonal), extreme right-hand side values.
		v[0] = 16'sh0100; v[4] = 16'sh0100; v[8] = 16'sh0100;
		v[9] = 16'sh7fff; v[10] = 16'sh8000; v[11] = 16'sh0001;
		send_matrix(v);
		// Unit diagonal with extreme b: solutions at both ends of the range, unsaturated.
		v[0] = 1; v[4] = 1; v[8] = 1;
		send_matrix(v);
		// x2 = -128.0 exactly: a negative result inside the range.
		v[0] = 16'sh0100; v[4] = 16'sh0100; v[8] = 16'sh0001;
		v[9] = 0; v[10] = 0; v[11] = 16'shff80;
		send_matrix(v);
		// x2 = +128.0: a positive result inside the range.
		v[11] = 16'sh0080;
		send_matrix(v);
		// Two equal rows: singular.
		foreach (v[i]) v[i] = elem_t'($urandom);
		v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
		send_matrix(v);
		// All fields at each extreme, then two mixed patterns.
		foreach (v[i]) v[i] = 16'sh7fff;
		send_matrix(v);
		foreach (v[i]) v[i] = 16'sh8000;
		send_matrix(v);
		foreach (v[i]) v[i] = (i % 2) ? 16'sh8000 : 16'sh7fff;
		send_matrix(v);
		foreach (v[i]) v[i] = (i % 4 == 0) ? 16'sh8000 : 16'shffff;
		send_matrix(v);
		drain_results();

		for (int n = 0; n < 1600; n++) begin
			calm = (n >= 600 && n < 900);
			if (n == 800)
				drain_results();
			mode = $urandom_range(0, 3);
			foreach (v[i]) v[i] = rand_elem(mode);
			// Sometimes force a linear dependency to reach the singular case.
			if ($urandom_range(0, 9) == 0) begin
				v[6] = v[0] + v[3]; v[7] = v[1] + v[4]; v[8] = v[2] + v[5];
			end
			send_matrix(v);
		end
		drain_results();
		repeat (LAT + 10) @(negedge clk);

		$display("Ran %0d requests, %0d results, %0d singular, %0d saturated.",
			board.n_req, board.n_res, board.n_sing, board.n_ovf);
		if (board.n_fail == 0 && board.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
